FILE: src/drp_pkg.sv
// Shared types and constants for the DNS A record response parser.
package drp_pkg;

   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned QTAIL_BYTES  = 4;
   localparam int unsigned AFIXED_BYTES = 10;

   localparam logic [15:0] FLAG_QR      = 16'h8000;
   localparam logic [15:0] FLAG_RCODE   = 16'h000F;
   localparam logic [7:0]  NAME_POINTER = 8'hC0;
   localparam logic [15:0] RR_TYPE_A    = 16'h0001;
   localparam logic [15:0] RR_CLASS_IN  = 16'h0001;
   localparam logic [15:0] A_RDATA_LEN  = 16'd4;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_QNAME,
      PH_QTAIL,
      PH_ANAME,
      PH_AFIXED,
      PH_RDATA,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      OUT_IGNORED,
      OUT_ERROR,
      OUT_NO_RECORD,
      OUT_FOUND
   } outcome_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] address;
      logic [31:0] ttl;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  header_count;
      logic [15:0] flags_word;
      logic [15:0] id_word;
      logic [15:0] question_left;
      logic [15:0] answer_left;
      logic [7:0]  label_left;
      logic [3:0]  tail_count;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [31:0] record_ttl;
      logic [15:0] rdata_left;
      logic [31:0] address_accum;
      outcome_type verdict;
      logic        verdict_done;
   } parse_state_type;

endpackage

FILE: src/drp_if.sv
// Handshake channels of the parser: message bytes, results and the ID register write.
interface drp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface drp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  outcome;
   logic [31:0] address;
   logic [31:0] ttl;
   modport source (output valid, outcome, address, ttl, input ready);
   modport sink   (input valid, outcome, address, ttl, output ready);
endinterface

interface drp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] expected_id;
   modport source (output valid, expected_id, input ready);
   modport sink   (input valid, expected_id, output ready);
endinterface

FILE: src/dns_a_record_response_parser.sv
// DNS A record response parser: top level with input and result registers.
// Accepts one message byte per clock while no final byte waits in the input register. Each
// byte is taken into an input register and consumed by the parser in the following cycle
// unless it has to wait; the verdict for a message is loaded into the result register at
// the end of the cycle in which the parser consumes the final byte and is presented on the
// result channel from that register. Non-final bytes never wait. A final byte waits in the
// input register only while an earlier result is still held on the result channel. Exactly
// one result is produced per message, on its final byte. The expected ID register is
// written through the csr channel, which is always ready.
module dns_a_record_response_parser
   import drp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   drp_req_if.sink    req_ch,
   drp_rsp_if.source  rsp_ch,
   drp_csr_if.sink    csr_ch
);

   logic [15:0]  expected_id_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   req_beat_type in_beat_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   result_type   rsp_data_ff;

   logic         rsp_free;
   logic         advance;
   logic         result_valid;
   result_type   result;

   assign csr_ch.ready = 1'b1;

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (!in_beat_ff.last_byte || rsp_free);
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_ch.valid || (in_valid_ff && !advance);
   assign rsp_valid_in = result_valid || (rsp_valid_ff && !rsp_ch.ready);

   drp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .expected_id  (expected_id_ff),
      .step_valid   (advance),
      .step         (in_beat_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            expected_id_ff <= csr_ch.expected_id;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_beat_ff.data_byte <= req_ch.data_byte;
         in_beat_ff.last_byte <= req_ch.last_byte;
      end
      if (result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.outcome = rsp_data_ff.outcome;
   assign rsp_ch.address = rsp_data_ff.address;
   assign rsp_ch.ttl     = rsp_data_ff.ttl;

   a_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.outcome != OUT_FOUND |-> rsp_ch.address == '0 && rsp_ch.ttl == '0)
      else $error("address or ttl nonzero without a found record");

   a_stall_only_on_final: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> in_valid_ff && in_beat_ff.last_byte && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled without a blocked final byte");

   a_result_presented: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> rsp_valid_ff)
      else $error("verdict not presented after final byte");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> rsp_free)
      else $error("verdict produced while previous result pending");

endmodule

FILE: src/drp_parser.sv
// Byte-wise DNS response parser state and verdict logic.
module drp_parser
   import drp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [15:0]  expected_id,
   input  logic         step_valid,
   input  req_beat_type step,
   output logic         result_valid,
   output result_type   result
);

   localparam parse_state_type PARSE_RESET = '{
      phase:         PH_HEADER,
      header_count:  '0,
      flags_word:    '0,
      id_word:       '0,
      question_left: '0,
      answer_left:   '0,
      label_left:    '0,
      tail_count:    '0,
      record_type:   '0,
      record_class:  '0,
      record_ttl:    '0,
      rdata_left:    '0,
      address_accum: '0,
      verdict:       OUT_IGNORED,
      verdict_done:  1'b0
   };

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type taken;

   function automatic parse_state_type finish(parse_state_type s, outcome_type v);
      parse_state_type r;
      r              = s;
      r.verdict      = v;
      r.verdict_done = 1'b1;
      r.phase        = PH_DONE;
      return r;
   endfunction

   function automatic parse_state_type after_questions(parse_state_type s);
      parse_state_type r;
      r = s;
      if (r.question_left != 16'd0) begin
         r.phase = PH_QNAME;
      end else if (r.answer_left != 16'd0) begin
         r.phase = PH_ANAME;
      end else begin
         r = finish(r, OUT_NO_RECORD);
      end
      r.label_left = '0;
      r.tail_count = '0;
      return r;
   endfunction

   function automatic parse_state_type record_done(parse_state_type s);
      parse_state_type r;
      r             = s;
      r.answer_left = r.answer_left - 16'd1;
      if (r.answer_left == 16'd0) begin
         r = finish(r, OUT_NO_RECORD);
      end else begin
         r.phase      = PH_ANAME;
         r.label_left = '0;
         r.tail_count = '0;
      end
      return r;
   endfunction

   // byte consumption
   always_comb begin : take_byte
      parse_state_type st;
      logic            name_end;
      logic [7:0]      b;
      st       = state_ff;
      name_end = 1'b0;
      b        = step.data_byte;
      if (step_valid) begin
         case (st.phase)
            PH_HEADER: begin
               if (st.header_count < 4'd2) begin
                  st.id_word = {st.id_word[7:0], b};
               end else if (st.header_count < 4'd4) begin
                  st.flags_word = {st.flags_word[7:0], b};
               end else if (st.header_count < 4'd6) begin
                  st.question_left = {st.question_left[7:0], b};
               end else if (st.header_count < 4'd8) begin
                  st.answer_left = {st.answer_left[7:0], b};
               end
               st.header_count = st.header_count + 4'd1;
               if (st.header_count >= 4'(HEADER_BYTES)) begin
                  if (st.id_word != expected_id) begin
                     st = finish(st, OUT_IGNORED);
                  end else if ((st.flags_word & FLAG_QR) == 16'd0 ||
                               (st.flags_word & FLAG_RCODE) != 16'd0) begin
                     st = finish(st, OUT_ERROR);
                  end else begin
                     st = after_questions(st);
                  end
               end
            end
            PH_QNAME, PH_ANAME: begin
               if (st.label_left != 8'd0) begin
                  st.label_left = st.label_left - 8'd1;
                  name_end = (st.label_left == 8'd0) && (st.tail_count != 4'd0);
               end else if (b == 8'd0) begin
                  name_end = 1'b1;
               end else if ((b & NAME_POINTER) == NAME_POINTER) begin
                  st.label_left = 8'd1;
                  st.tail_count = 4'd1;
               end else begin
                  st.label_left = b;
               end
               if (name_end) begin
                  st.phase      = (st.phase == PH_QNAME) ? PH_QTAIL : PH_AFIXED;
                  st.tail_count = '0;
                  st.label_left = '0;
               end
            end
            PH_QTAIL: begin
               st.tail_count = st.tail_count + 4'd1;
               if (st.tail_count >= 4'(QTAIL_BYTES)) begin
                  st.question_left = st.question_left - 16'd1;
                  st = after_questions(st);
               end
            end
            PH_AFIXED: begin
               if (st.tail_count < 4'd2) begin
                  st.record_type = {st.record_type[7:0], b};
               end else if (st.tail_count < 4'd4) begin
                  st.record_class = {st.record_class[7:0], b};
               end else if (st.tail_count < 4'd8) begin
                  st.record_ttl = {st.record_ttl[23:0], b};
               end else begin
                  st.rdata_left = {st.rdata_left[7:0], b};
               end
               st.tail_count = st.tail_count + 4'd1;
               if (st.tail_count >= 4'(AFIXED_BYTES)) begin
                  st.tail_count = '0;
                  if (st.rdata_left != A_RDATA_LEN) begin
                     st.record_type = '0;
                  end
                  st.address_accum = '0;
                  if (st.rdata_left == 16'd0) begin
                     st = record_done(st);
                  end else begin
                     st.phase = PH_RDATA;
                  end
               end
            end
            PH_RDATA: begin
               st.address_accum = {st.address_accum[23:0], b};
               st.rdata_left    = st.rdata_left - 16'd1;
               if (st.rdata_left == 16'd0) begin
                  if (st.record_type == RR_TYPE_A && st.record_class == RR_CLASS_IN) begin
                     st = finish(st, OUT_FOUND);
                  end else begin
                     st = record_done(st);
                  end
               end
            end
            default: begin
            end
         endcase
      end
      taken = st;
   end

   always_comb begin : next_state
      state_in = taken;
      if (step_valid && step.last_byte) begin
         state_in = PARSE_RESET;
      end
   end

   always_comb begin : verdict_out
      result_valid = step_valid && step.last_byte;
      if (taken.verdict_done && taken.verdict == OUT_FOUND) begin
         result.outcome = OUT_FOUND;
         result.address = taken.address_accum;
         result.ttl     = taken.record_ttl;
      end else begin
         result.outcome = taken.verdict_done ? taken.verdict : OUT_IGNORED;
         result.address = '0;
         result.ttl     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
